// ----- rtl/nvm_pkg.sv -----
package nvm_pkg;

  // sizes fixed by the beat fields
  localparam int unsigned OFF_W      = 12;
  localparam int unsigned ADDR_W     = 14;
  localparam int unsigned ROWCOL_W   = 6;
  localparam int unsigned IN_TDATA_W = 40;

  // defaults for the top level parameters
  localparam int unsigned MEM_BYTES_DEF = 4096;
  localparam int unsigned BASE_ADDR_DEF = 8192;

  // action codes
  localparam logic [1:0] ACT_READ    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_PATTERN = 2'd2;
  localparam logic [1:0] ACT_PALETTE = 2'd3;

  // mirroring modes, code 3 folds nothing
  localparam logic [1:0] MIRROR_NONE  = 2'd0;
  localparam logic [1:0] MIRROR_HORIZ = 2'd1;
  localparam logic [1:0] MIRROR_VERT  = 2'd2;

  // fold boundaries
  localparam logic [OFF_W-1:0] FOLD_QUARTER = 12'h400;
  localparam logic [OFF_W-1:0] FOLD_HALF    = 12'h800;
  localparam logic [OFF_W-1:0] FOLD_3QUART  = 12'hC00;

  // tile grid
  localparam logic [ROWCOL_W-1:0] ROWS_PER_TABLE = 6'd30;
  localparam logic [ROWCOL_W-1:0] ROWS_TOTAL     = 6'd60;

  typedef enum logic [1:0] {
    KIND_WRITE,
    KIND_BYTE,
    KIND_PALETTE,
    KIND_ERROR
  } res_kind_e;

  typedef struct packed {
    res_kind_e        kind;
    logic [OFF_W-1:0] offset;
    logic [7:0]       wdata;
    logic [1:0]       quad;
  } off_info_t;

  typedef struct packed {
    logic we;
    logic re;
  } mem_req_t;

endpackage

// ----- rtl/nvm_offset.sv -----
module nvm_offset import nvm_pkg::*; #(
  parameter int unsigned MEMORY_BYTES = MEM_BYTES_DEF,
  parameter int unsigned BASE_ADDRESS = BASE_ADDR_DEF
) (
  input  logic [1:0]          action_i,
  input  logic [ADDR_W-1:0]   address_i,
  input  logic [7:0]          wdata_i,
  input  logic [ROWCOL_W-1:0] tile_row_i,
  input  logic [ROWCOL_W-1:0] tile_col_i,
  output off_info_t           info_o
);

  localparam int unsigned BaseRem = BASE_ADDRESS % MEMORY_BYTES;
  localparam logic [14:0] Mult4   = 15'(4 * MEMORY_BYTES);
  localparam logic [14:0] Mult2   = 15'(2 * MEMORY_BYTES);
  localparam logic [14:0] Mult1   = 15'(MEMORY_BYTES);
  localparam logic [14:0] RemW    = 15'(BaseRem);
  localparam logic [14:0] RemComp = 15'(MEMORY_BYTES - BaseRem);
  localparam logic [12:0] MemW    = 13'(MEMORY_BYTES);

  logic [14:0]         a0, a1, a2, a3, bus_full;
  logic [OFF_W-1:0]    bus_off;
  logic                row_hi, pos_err;
  logic [4:0]          ly, lx;
  logic [1:0]          table_sel;
  logic [OFF_W-1:0]    pat_raw, attr_raw;
  logic [OFF_W-1:0]    pat_off, attr_off;

  // address modulo the store size, then shift by the base remainder
  always_comb begin
    a0 = {1'b0, address_i};
    a1 = (a0 >= Mult4) ? a0 - Mult4 : a0;
    a2 = (a1 >= Mult2) ? a1 - Mult2 : a1;
    a3 = (a2 >= Mult1) ? a2 - Mult1 : a2;
    bus_full = (a3 >= RemW) ? a3 - RemW : a3 + RemComp;
    bus_off  = bus_full[OFF_W-1:0];
  end

  always_comb begin
    pos_err   = tile_row_i >= ROWS_TOTAL;
    row_hi    = tile_row_i >= ROWS_PER_TABLE;
    ly        = row_hi ? 5'(tile_row_i - ROWS_PER_TABLE) : tile_row_i[4:0];
    lx        = tile_col_i[4:0];
    table_sel = {row_hi, tile_col_i[5]};
    pat_raw   = {table_sel, ly, lx};
    attr_raw  = {table_sel, 4'b1111, ly[4:2], lx[4:2]};
    pat_off   = ({1'b0, pat_raw} >= MemW) ? 12'({1'b0, pat_raw} - MemW) : pat_raw;
    attr_off  = ({1'b0, attr_raw} >= MemW) ? 12'({1'b0, attr_raw} - MemW) : attr_raw;
  end

  always_comb begin
    info_o.wdata = wdata_i;
    info_o.quad  = {ly[1], lx[1]};
    case (action_i)
      ACT_READ: begin
        info_o.kind   = KIND_BYTE;
        info_o.offset = bus_off;
      end
      ACT_WRITE: begin
        info_o.kind   = KIND_WRITE;
        info_o.offset = bus_off;
      end
      ACT_PATTERN: begin
        info_o.kind   = pos_err ? KIND_ERROR : KIND_BYTE;
        info_o.offset = pat_off;
      end
      ACT_PALETTE: begin
        info_o.kind   = pos_err ? KIND_ERROR : KIND_PALETTE;
        info_o.offset = attr_off;
      end
      default: begin
        info_o.kind   = KIND_BYTE;
        info_o.offset = bus_off;
      end
    endcase
  end

endmodule

// ----- rtl/nvm_fold.sv -----
module nvm_fold import nvm_pkg::*; #(
  parameter int unsigned MEMORY_BYTES = MEM_BYTES_DEF,
  localparam int unsigned IdxW        = $clog2(MEMORY_BYTES)
) (
  input  logic [OFF_W-1:0] offset_i,
  input  logic [1:0]       mode_i,
  output logic [IdxW-1:0]  index_o
);

  logic [OFF_W-1:0] folded;

  always_comb begin
    folded = offset_i;
    case (mode_i)
      MIRROR_VERT: begin
        if (offset_i >= FOLD_HALF) begin
          folded = offset_i - FOLD_HALF;
        end
      end
      MIRROR_HORIZ: begin
        if ((offset_i >= FOLD_QUARTER && offset_i < FOLD_HALF) || offset_i >= FOLD_3QUART) begin
          folded = offset_i - FOLD_QUARTER;
        end
      end
      default: begin
        folded = offset_i;
      end
    endcase
    index_o = folded[IdxW-1:0];
  end

endmodule

// ----- rtl/nvm_mem.sv -----
module nvm_mem import nvm_pkg::*; #(
  parameter int unsigned MEMORY_BYTES = MEM_BYTES_DEF,
  localparam int unsigned IdxW        = $clog2(MEMORY_BYTES)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mem_req_t        req_i,
  input  logic [IdxW-1:0] addr_i,
  input  logic [7:0]      wdata_i,
  output logic [7:0]      rdata_o,
  output logic            busy_o
);

  logic [7:0]      mem_q [MEMORY_BYTES];
  logic [7:0]      rdata_q;
  logic            clr_q, clr_d;
  logic [IdxW-1:0] cnt_q, cnt_d;

  // clearing sweep after reset, one entry a cycle
  always_comb begin
    clr_d = clr_q;
    cnt_d = cnt_q;
    if (clr_q) begin
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == IdxW'(MEMORY_BYTES - 1)) begin
        clr_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q <= 1'b1;
      cnt_q <= '0;
    end else begin
      clr_q <= clr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_q) begin
      mem_q[cnt_q] <= '0;
    end else if (req_i.we) begin
      mem_q[addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.re) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = clr_q;

endmodule

// ----- rtl/nametable_vram_with_mirroring.sv -----
// tile-map store with mirroring, byte access and tile queries
//
// input stream s_axis: one beat per request (byte read, byte write, pattern
// query or palette query); output stream m_axis: one beat per read or query,
// none for a write. results leave in the order the requests came in
// config channel cfg_*: writes the 2-bit mirroring mode, always ready; the user must
// see it is changed only while no request is in flight; the block does not enforce it
//
// path: a request beat is loaded into stage a (its offset, before folding),
// then into the memory read register and stage c, then into the output
// register that drives m_axis
// throughput: one request per cycle unless m_axis stalls or the sweep runs, set
// by the single memory port that serves one read or one write each cycle
//
// after reset the store is swept to zero, one entry a cycle, so s_axis_tready
// stays low until every entry is cleared; config writes are taken during the sweep
// when m_axis stalls, the output register holds its beat and the stages behind
// it keep filling until each holds an item, then s_axis_tready drops
module nametable_vram_with_mirroring import nvm_pkg::*; #(
  parameter int unsigned MEMORY_BYTES = MEM_BYTES_DEF,
  parameter int unsigned BASE_ADDRESS = BASE_ADDR_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // action[1:0], address[15:2], write_data[23:16], tile_row[29:24],
  // tile_col[35:30], zero fill[39:36]
  input  logic [IN_TDATA_W-1:0] s_axis_tdata,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // result_data[7:0]
  output logic [7:0]            m_axis_tdata,
  // position_error[0]
  output logic                  m_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  input  logic [1:0]            cfg_data_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o
);

  localparam int unsigned IdxW = $clog2(MEMORY_BYTES);

  // mirroring mode register
  logic [1:0] mode_q, mode_d;

  // stage a: offset of the accepted beat, before folding
  off_info_t  in_info;
  logic       a_valid_q, a_valid_d;
  off_info_t  a_info_q;

  // stage c: memory read data plus what to do with it
  logic       c_valid_q, c_valid_d;
  res_kind_e  c_kind_q;
  logic [1:0] c_quad_q;

  // output register
  logic       o_valid_q, o_valid_d;
  logic [7:0] o_data_q;
  logic       o_err_q;

  logic            mem_busy;
  logic [7:0]      mem_rdata;
  logic [IdxW-1:0] mem_index;
  mem_req_t        mem_req;

  logic       o_free, c_adv, a_leave, a_adv, in_fire, a_is_write;
  logic [7:0] res_data;
  logic       res_err;

  nvm_offset #(
    .MEMORY_BYTES (MEMORY_BYTES),
    .BASE_ADDRESS (BASE_ADDRESS)
  ) u_offset (
    .action_i   (s_axis_tdata[1:0]),
    .address_i  (s_axis_tdata[15:2]),
    .wdata_i    (s_axis_tdata[23:16]),
    .tile_row_i (s_axis_tdata[29:24]),
    .tile_col_i (s_axis_tdata[35:30]),
    .info_o     (in_info)
  );

  // mirroring is applied against the current mode as the item hits memory
  nvm_fold #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_fold (
    .offset_i (a_info_q.offset),
    .mode_i   (mode_q),
    .index_o  (mem_index)
  );

  nvm_mem #(
    .MEMORY_BYTES (MEMORY_BYTES)
  ) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mem_req),
    .addr_i  (mem_index),
    .wdata_i (a_info_q.wdata),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  // each stage moves when the one ahead of it frees up
  always_comb begin
    o_free        = !o_valid_q || m_axis_tready;
    c_adv         = !c_valid_q || o_free;
    a_leave       = a_valid_q && c_adv;
    a_adv         = !a_valid_q || c_adv;
    s_axis_tready = a_adv && !mem_busy;
    in_fire       = s_axis_tvalid && s_axis_tready;
    a_is_write    = a_info_q.kind == KIND_WRITE;

    // one access per cycle while stage a moves on, in order, so a read right after a
    // write to the same entry already sees the new byte
    mem_req.we = a_leave && a_is_write;
    mem_req.re = a_leave && !a_is_write;

    a_valid_d = a_adv ? in_fire : a_valid_q;
    c_valid_d = c_adv ? (a_valid_q && !a_is_write) : c_valid_q;
    o_valid_d = (c_valid_q && o_free) ? 1'b1 : (m_axis_tready ? 1'b0 : o_valid_q);

    mode_d = cfg_valid_i ? cfg_data_i : mode_q;
  end

  // result from the read byte
  always_comb begin
    case (c_kind_q)
      KIND_BYTE: begin
        res_data = mem_rdata;
        res_err  = 1'b0;
      end
      KIND_PALETTE: begin
        // quadrant picks one of four 2-bit fields
        res_data = {6'd0, mem_rdata[{c_quad_q, 1'b0} +: 2]};
        res_err  = 1'b0;
      end
      KIND_ERROR: begin
        res_data = '0;
        res_err  = 1'b1;
      end
      default: begin
        res_data = '0;
        res_err  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      mode_q    <= MIRROR_NONE;
    end else begin
      a_valid_q <= a_valid_d;
      c_valid_q <= c_valid_d;
      o_valid_q <= o_valid_d;
      mode_q    <= mode_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_info_q <= in_info;
    end
    if (c_adv) begin
      c_kind_q <= a_info_q.kind;
      c_quad_q <= a_info_q.quad;
    end
    if (c_valid_q && o_free) begin
      o_data_q <= res_data;
      o_err_q  <= res_err;
    end
  end

  assign m_axis_tvalid = o_valid_q;
  assign m_axis_tdata  = o_data_q;
  assign m_axis_tuser  = o_err_q;
  assign cfg_ready_o   = 1'b1;

endmodule

// ----- rtl/nvm_checker.sv -----
module nvm_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  // stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("output beat changed while stalled");

  // an out-of-range query carries zero data
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
    else $error("position error with nonzero data");

  // clearing sweep blocks input right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !s_axis_tready)
    else $error("input ready during clearing sweep");

  // nothing comes out right after reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$past(rst_ni) |-> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind nametable_vram_with_mirroring nvm_checker u_nvm_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);
